@@ rtl/core/fingertip_defect_filter_assert.svh @@
// Assertion macros for the fingertip defect filter.
// Define ASSERT_OFF to compile every check away.
`ifndef FINGERTIP_DEFECT_FILTER_ASSERT_SVH
`define FINGERTIP_DEFECT_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define FDF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("fingertip_defect_filter: check failed");
// Condition must never be seen outside reset.
`define FDF_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("fingertip_defect_filter: forbidden condition");
`else
`define FDF_ASSERT(lbl, prop)
`define FDF_NEVER(lbl, cond)
`endif

`endif

@@ rtl/core/fdf_pkg.sv @@
package fdf_pkg;

   // field widths
   localparam int COORD_BITS_DEF      = 12;
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int CSR_DATA_BITS       = 10;
   localparam int CSR_INDEX_BITS      = 3;

   // CORDIC datapath
   localparam int CORDIC_STEPS = 22;
   localparam int CORDIC_W     = 63;   // x/y working width
   localparam int NORM_MSB     = 59;   // normalized magnitude sits in [2^59, 2^60)
   localparam int ACC_FRAC     = 16;   // fraction bits of the angle accumulator
   localparam int ACC_W        = 27;   // accumulator width, signed
   localparam int SHIFT_BITS   = 6;
   // pre-rotate, shift, iterations, rounding
   localparam int CORDIC_LAT   = CORDIC_STEPS + 3;

   localparam logic signed [ACC_W-1:0] DEG180_Q16 = ACC_W'(180 * 65536);

   // register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIR_MIN   = 3'd0,
      CSR_DIR_MAX   = 3'd1,
      CSR_APEX_MIN  = 3'd2,
      CSR_APEX_MAX  = 3'd3,
      CSR_LEN_RATIO = 3'd4
   } csr_index_type;

   localparam logic signed [8:0] DIR_MIN_RST   = -9'sd30;
   localparam logic signed [8:0] DIR_MAX_RST   = 9'sd160;
   localparam logic [7:0]        APEX_MIN_RST  = 8'd20;
   localparam logic [7:0]        APEX_MAX_RST  = 8'd120;
   localparam logic [9:0]        LEN_RATIO_RST = 10'd100;

   localparam logic [19:0] MILLION = 20'd1000000;

   // atan(2^-i) in degrees, Q16, rounded
   function automatic logic signed [ACC_W-1:0] atan_q16(input int step);
      logic signed [ACC_W-1:0] t;
      case (step)
         0:  t = ACC_W'(2949120);
         1:  t = ACC_W'(1740967);
         2:  t = ACC_W'(919879);
         3:  t = ACC_W'(466945);
         4:  t = ACC_W'(234379);
         5:  t = ACC_W'(117304);
         6:  t = ACC_W'(58666);
         7:  t = ACC_W'(29335);
         8:  t = ACC_W'(14668);
         9:  t = ACC_W'(7334);
         10: t = ACC_W'(3667);
         11: t = ACC_W'(1833);
         12: t = ACC_W'(917);
         13: t = ACC_W'(458);
         14: t = ACC_W'(229);
         15: t = ACC_W'(115);
         16: t = ACC_W'(57);
         17: t = ACC_W'(29);
         18: t = ACC_W'(14);
         19: t = ACC_W'(7);
         20: t = ACC_W'(4);
         21: t = ACC_W'(2);
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/core/fdf_cordic.sv @@
module fdf_cordic #(
   parameter int IN_W            = 13,
   parameter int ANGLE_FRAC_BITS = fdf_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic signed [IN_W-1:0]               x_i,
   input  logic signed [IN_W-1:0]               y_i,
   output logic signed [ANGLE_FRAC_BITS+9:0]    angle_o
);
   import fdf_pkg::*;

   localparam int EW = IN_W + 1;
   localparam int AW = ANGLE_FRAC_BITS + 10;
   localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;

   // pre-rotation and leading-one search
   logic signed [EW-1:0]         xe, ye, xa_in, ya_in, ymag;
   logic [EW-1:0]                mag;
   logic [SHIFT_BITS-1:0]        msb, k_in;
   logic signed [ACC_W-1:0]      z0_in;
   logic signed [EW-1:0]         xa_ff, ya_ff;
   logic [SHIFT_BITS-1:0]        k_ff;
   logic signed [ACC_W-1:0]      za_ff;

   always_comb begin
      xe = EW'(x_i);
      ye = EW'(y_i);
      if (xe < 0) begin
         xa_in = -xe;
         ya_in = -ye;
         z0_in = (ye >= 0) ? DEG180_Q16 : -DEG180_Q16;
      end else begin
         xa_in = xe;
         ya_in = ye;
         z0_in = '0;
      end
      ymag = (ya_in < 0) ? -ya_in : ya_in;
      mag  = xa_in | ymag;
      msb  = '0;
      for (int b = 0; b < EW; b++) begin
         if (mag[b]) msb = SHIFT_BITS'(b);
      end
      k_in = SHIFT_BITS'(NORM_MSB) - msb;
   end

   always_ff @(posedge clock) begin
      xa_ff <= xa_in;
      ya_ff <= ya_in;
      za_ff <= z0_in;
      k_ff  <= k_in;
   end

   // normalize: one barrel shift
   logic signed [CORDIC_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [ACC_W-1:0]    z_ff [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_W'(xa_ff) <<< k_ff;
      y_ff[0] <= CORDIC_W'(ya_ff) <<< k_ff;
      z_ff[0] <= za_ff;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] dx, dy;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + dy;
            y_ff[i+1] <= y_ff[i] - dx;
            z_ff[i+1] <= z_ff[i] + atan_q16(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - dy;
            y_ff[i+1] <= y_ff[i] + dx;
            z_ff[i+1] <= z_ff[i] - atan_q16(i);
         end
      end
   end

   // round half up to the output fraction
   logic signed [ACC_W-1:0] zr_in;
   logic signed [AW-1:0]    angle_ff;
   assign zr_in = (z_ff[CORDIC_STEPS] + (ACC_W'(1) <<< (SH - 1))) >>> SH;

   always_ff @(posedge clock) begin
      angle_ff <= zr_in[AW-1:0];
   end

   assign angle_o = angle_ff;

   // y ends unused apart from steering; x only feeds the rotation
endmodule

@@ rtl/core/fingertip_defect_filter.sv @@
// Fingertip defect filter.
// One item is a convexity defect: start, end and deepest points, the hand box
// centre and the box height, all on req_* ports. An item is taken at a rising
// edge with start high and busy low. busy is high only during reset, so one
// item can enter in every cycle.
// Each result appears on rsp_* for one cycle with rsp_valid high: the decision
// rsp_is_fingertip and the start point as rsp_tip_x / rsp_tip_y. The receiver
// cannot stall, so the pipeline never stops.
// Throughput is one item per cycle. Five stages form differences, squares,
// apex choice, products and sums; two CORDIC pipelines of 25 stages
// (pre-rotation, normalizing shift, 22 rotations, rounding) give both angles;
// one last stage compares and registers the result.
// Configuration is written through csr_we / csr_index / csr_wdata; the user
// must write it only while no item is in flight, as the block does not
// enforce this. Reset restores the default limits and empties the pipeline;
// items in flight are dropped.
`include "fingertip_defect_filter_assert.svh"

module fingertip_defect_filter #(
   parameter int COORD_BITS      = fdf_pkg::COORD_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = fdf_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [COORD_BITS-1:0]              req_start_x,
   input  logic [COORD_BITS-1:0]              req_start_y,
   input  logic [COORD_BITS-1:0]              req_end_x,
   input  logic [COORD_BITS-1:0]              req_end_y,
   input  logic [COORD_BITS-1:0]              req_far_x,
   input  logic [COORD_BITS-1:0]              req_far_y,
   input  logic [COORD_BITS-1:0]              req_centre_x,
   input  logic [COORD_BITS-1:0]              req_centre_y,
   input  logic [COORD_BITS-1:0]              req_box_height,
   output logic                               rsp_valid,
   output logic                               rsp_is_fingertip,
   output logic [COORD_BITS-1:0]              rsp_tip_x,
   output logic [COORD_BITS-1:0]              rsp_tip_y,
   input  logic                               csr_we,
   input  logic [fdf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fdf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import fdf_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int DFW   = CB + 1;        // point difference, signed
   localparam int DW    = 2 * CB + 1;    // squared distance, unsigned
   localparam int PW    = CB + 2;        // apex vectors, signed
   localparam int MW    = 2 * PW;        // products
   localparam int AIW   = MW + 1;        // dot and cross
   localparam int LW    = DW + 20;       // scaled squared length
   localparam int RW    = CB + 10;       // ratio times height
   localparam int AW    = ANGLE_FRAC_BITS + 10;
   localparam int FRONT = 5;
   localparam int VLEN  = FRONT + CORDIC_LAT;
   localparam int LAT   = VLEN + 1;

   // ---------------- configuration registers
   logic signed [8:0] dir_min_ff, dir_max_ff;
   logic [7:0]        apex_min_ff, apex_max_ff;
   logic [9:0]        ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_min_ff  <= DIR_MIN_RST;
         dir_max_ff  <= DIR_MAX_RST;
         apex_min_ff <= APEX_MIN_RST;
         apex_max_ff <= APEX_MAX_RST;
         ratio_ff    <= LEN_RATIO_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIR_MIN:   dir_min_ff  <= csr_wdata[8:0];
            CSR_DIR_MAX:   dir_max_ff  <= csr_wdata[8:0];
            CSR_APEX_MIN:  apex_min_ff <= csr_wdata[7:0];
            CSR_APEX_MAX:  apex_max_ff <= csr_wdata[7:0];
            CSR_LEN_RATIO: ratio_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake and valid line
   logic            accept;
   logic [VLEN-1:0] vld_ff;
   logic            rsp_valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[VLEN-2:0], accept};
         rsp_valid_ff <= vld_ff[VLEN-1];
      end
   end

   // ---------------- stage 1: differences
   logic signed [DFW-1:0] s1_dcx_ff, s1_dcy_ff, s1_sfx_ff, s1_sfy_ff, s1_efx_ff, s1_efy_ff;
   logic [CB-1:0]         s1_h_ff, s1_tx_ff, s1_ty_ff;

   always_ff @(posedge clock) begin
      s1_dcx_ff <= $signed({1'b0, req_centre_x}) - $signed({1'b0, req_start_x});
      s1_dcy_ff <= $signed({1'b0, req_centre_y}) - $signed({1'b0, req_start_y});
      s1_sfx_ff <= $signed({1'b0, req_start_x}) - $signed({1'b0, req_far_x});
      s1_sfy_ff <= $signed({1'b0, req_start_y}) - $signed({1'b0, req_far_y});
      s1_efx_ff <= $signed({1'b0, req_end_x}) - $signed({1'b0, req_far_x});
      s1_efy_ff <= $signed({1'b0, req_end_y}) - $signed({1'b0, req_far_y});
      s1_h_ff   <= req_box_height;
      s1_tx_ff  <= req_start_x;
      s1_ty_ff  <= req_start_y;
   end

   // ---------------- stage 2: squared distances, ratio times height
   logic signed [2*DFW-1:0] sq_sx, sq_sy, sq_ex, sq_ey;
   logic [DW-1:0]           s2_d1_ff, s2_d2_ff;
   logic [RW-1:0]           s2_rh_ff;
   logic signed [DFW-1:0]   s2_dcx_ff, s2_dcy_ff, s2_sfx_ff, s2_sfy_ff, s2_efx_ff, s2_efy_ff;
   logic [CB-1:0]           s2_tx_ff, s2_ty_ff;

   assign sq_sx = s1_sfx_ff * s1_sfx_ff;
   assign sq_sy = s1_sfy_ff * s1_sfy_ff;
   assign sq_ex = s1_efx_ff * s1_efx_ff;
   assign sq_ey = s1_efy_ff * s1_efy_ff;

   always_ff @(posedge clock) begin
      s2_d1_ff  <= DW'(sq_sx[2*CB-1:0]) + DW'(sq_sy[2*CB-1:0]);
      s2_d2_ff  <= DW'(sq_ex[2*CB-1:0]) + DW'(sq_ey[2*CB-1:0]);
      s2_rh_ff  <= RW'(ratio_ff) * RW'(s1_h_ff);
      s2_dcx_ff <= s1_dcx_ff;
      s2_dcy_ff <= s1_dcy_ff;
      s2_sfx_ff <= s1_sfx_ff;
      s2_sfy_ff <= s1_sfy_ff;
      s2_efx_ff <= s1_efx_ff;
      s2_efy_ff <= s1_efy_ff;
      s2_tx_ff  <= s1_tx_ff;
      s2_ty_ff  <= s1_ty_ff;
   end

   // ---------------- stage 3: pick the apex, scale lengths
   logic signed [PW-1:0]  sfx_w, sfy_w, efx_w, efy_w;
   logic signed [PW-1:0]  p1_in, p2_in, q1_in, q2_in;
   logic signed [PW-1:0]  s3_p1_ff, s3_p2_ff, s3_q1_ff, s3_q2_ff;
   logic [LW-1:0]         s3_lhs_ff;
   logic [2*RW-1:0]       s3_rh2_ff;
   logic signed [DFW-1:0] s3_dcx_ff, s3_dcy_ff;
   logic [CB-1:0]         s3_tx_ff, s3_ty_ff;

   always_comb begin
      sfx_w = PW'(s2_sfx_ff);
      sfy_w = PW'(s2_sfy_ff);
      efx_w = PW'(s2_efx_ff);
      efy_w = PW'(s2_efy_ff);
      if (s2_d1_ff < s2_d2_ff) begin
         // apex at end point
         p1_in = sfx_w - efx_w;
         p2_in = sfy_w - efy_w;
         q1_in = -efx_w;
         q2_in = -efy_w;
      end else begin
         // apex at start point, ties included
         p1_in = efx_w - sfx_w;
         p2_in = efy_w - sfy_w;
         q1_in = -sfx_w;
         q2_in = -sfy_w;
      end
   end

   always_ff @(posedge clock) begin
      s3_p1_ff  <= p1_in;
      s3_p2_ff  <= p2_in;
      s3_q1_ff  <= q1_in;
      s3_q2_ff  <= q2_in;
      s3_lhs_ff <= LW'(s2_d1_ff) * LW'(MILLION);
      s3_rh2_ff <= (2*RW)'(s2_rh_ff) * (2*RW)'(s2_rh_ff);
      s3_dcx_ff <= s2_dcx_ff;
      s3_dcy_ff <= s2_dcy_ff;
      s3_tx_ff  <= s2_tx_ff;
      s3_ty_ff  <= s2_ty_ff;
   end

   // ---------------- stage 4: apex products, length test
   logic signed [MW-1:0]  s4_m11_ff, s4_m22_ff, s4_m12_ff, s4_m21_ff;
   logic                  s4_az_ff, s4_lok_ff;
   logic signed [DFW-1:0] s4_dcx_ff, s4_dcy_ff;
   logic [CB-1:0]         s4_tx_ff, s4_ty_ff;

   always_ff @(posedge clock) begin
      s4_m11_ff <= s3_p1_ff * s3_q1_ff;
      s4_m22_ff <= s3_p2_ff * s3_q2_ff;
      s4_m12_ff <= s3_p1_ff * s3_q2_ff;
      s4_m21_ff <= s3_p2_ff * s3_q1_ff;
      s4_az_ff  <= (s3_p1_ff == '0 && s3_p2_ff == '0) ||
                   (s3_q1_ff == '0 && s3_q2_ff == '0);
      s4_lok_ff <= s3_lhs_ff > LW'(s3_rh2_ff);
      s4_dcx_ff <= s3_dcx_ff;
      s4_dcy_ff <= s3_dcy_ff;
      s4_tx_ff  <= s3_tx_ff;
      s4_ty_ff  <= s3_ty_ff;
   end

   // ---------------- stage 5: dot and cross, CORDIC operands
   logic signed [AIW-1:0] cross_in;
   logic signed [AIW-1:0] s5_dot_ff, s5_cr_ff;
   logic signed [DFW-1:0] s5_dcx_ff, s5_dcy_ff;

   typedef struct packed {
      logic          dir_zero;
      logic          apex_zero;
      logic          len_ok;
      logic [CB-1:0] tip_x;
      logic [CB-1:0] tip_y;
   } side_type;

   side_type side_ff [0:CORDIC_LAT];

   assign cross_in = AIW'(s4_m12_ff) - AIW'(s4_m21_ff);

   // load the side flags and carry them beside the CORDIC pipelines
   always_ff @(posedge clock) begin
      s5_dot_ff <= AIW'(s4_m11_ff) + AIW'(s4_m22_ff);
      s5_cr_ff  <= (cross_in < 0) ? -cross_in : cross_in;
      s5_dcx_ff <= s4_dcx_ff;
      s5_dcy_ff <= s4_dcy_ff;
      side_ff[0].dir_zero  <= (s4_dcx_ff == '0) && (s4_dcy_ff == '0);
      side_ff[0].apex_zero <= s4_az_ff;
      side_ff[0].len_ok    <= s4_lok_ff;
      side_ff[0].tip_x     <= s4_tx_ff;
      side_ff[0].tip_y     <= s4_ty_ff;
      for (int j = 1; j <= CORDIC_LAT; j++) begin
         side_ff[j] <= side_ff[j-1];
      end
   end

   // ---------------- angle units
   logic signed [AW-1:0] dir_angle, apex_angle;

   fdf_cordic #(
      .IN_W            (DFW),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_dir_cordic (
      .clock   (clock),
      .x_i     (s5_dcx_ff),
      .y_i     (s5_dcy_ff),
      .angle_o (dir_angle)
   );

   fdf_cordic #(
      .IN_W            (AIW),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_apex_cordic (
      .clock   (clock),
      .x_i     (s5_dot_ff),
      .y_i     (s5_cr_ff),
      .angle_o (apex_angle)
   );

   // ---------------- final compare and result register
   logic signed [AW-1:0] dir_lo, dir_hi, apex_lo, apex_hi;
   logic                 pass_in;
   side_type             side_out;
   logic                 tip_ok_ff;
   logic [CB-1:0]        tip_x_ff, tip_y_ff;

   assign side_out = side_ff[CORDIC_LAT];
   assign dir_lo   = AW'(dir_min_ff) <<< ANGLE_FRAC_BITS;
   assign dir_hi   = AW'(dir_max_ff) <<< ANGLE_FRAC_BITS;
   assign apex_lo  = $signed(AW'(apex_min_ff)) <<< ANGLE_FRAC_BITS;
   assign apex_hi  = $signed(AW'(apex_max_ff)) <<< ANGLE_FRAC_BITS;

   assign pass_in = !side_out.dir_zero && !side_out.apex_zero && side_out.len_ok &&
                    (dir_angle > dir_lo) && (dir_angle < dir_hi) &&
                    (apex_angle > apex_lo) && (apex_angle < apex_hi);

   always_ff @(posedge clock) begin
      tip_ok_ff <= pass_in && vld_ff[VLEN-1];
      tip_x_ff  <= side_out.tip_x;
      tip_y_ff  <= side_out.tip_y;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_fingertip = tip_ok_ff;
   assign rsp_tip_x        = tip_x_ff;
   assign rsp_tip_y        = tip_y_ff;

   // ---------------- checks
   `FDF_ASSERT(a_rsp_follows_item, rsp_valid |-> $past(accept, LAT))
   `FDF_ASSERT(a_tip_x_is_start, rsp_valid |-> rsp_tip_x == $past(req_start_x, LAT))
   `FDF_ASSERT(a_tip_y_is_start, rsp_valid |-> rsp_tip_y == $past(req_start_y, LAT))
   `FDF_NEVER(a_tip_without_valid, rsp_is_fingertip && !rsp_valid)

endmodule

@@ tb/fingertip_defect_filter_checker.sv @@
module fingertip_defect_filter_checker
   import fdf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [COORD_BITS_DEF-1:0] req_start_x,
   input  logic [COORD_BITS_DEF-1:0] req_start_y,
   input  logic [COORD_BITS_DEF-1:0] req_end_x,
   input  logic [COORD_BITS_DEF-1:0] req_end_y,
   input  logic [COORD_BITS_DEF-1:0] req_far_x,
   input  logic [COORD_BITS_DEF-1:0] req_far_y,
   input  logic [COORD_BITS_DEF-1:0] req_centre_x,
   input  logic [COORD_BITS_DEF-1:0] req_centre_y,
   input  logic [COORD_BITS_DEF-1:0] req_box_height,
   input  logic                      rsp_valid,
   input  logic                      rsp_is_fingertip,
   input  logic [COORD_BITS_DEF-1:0] rsp_tip_x,
   input  logic [COORD_BITS_DEF-1:0] rsp_tip_y,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   typedef struct packed {
      logic                      tip;
      logic [COORD_BITS_DEF-1:0] x;
      logic [COORD_BITS_DEF-1:0] y;
   } verdict_type;

   localparam int FRAC = ANGLE_FRAC_BITS_DEF;

   // atan(2^-i) in degrees, 16 fraction bits
   localparam longint ATAN_TAB [22] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};

   logic signed [8:0] lim_dir_lo, lim_dir_hi;
   logic [7:0]        lim_apex_lo, lim_apex_hi;
   logic [9:0]        len_ratio;
   verdict_type       verdict_q[$];

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // vectoring CORDIC: angle of (x, y) in degrees with FRAC fraction bits
   function automatic longint angle_of(longint x, longint y);
      longint z, dx, dy, u;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x;
         y = -y;
      end
      while (abs64(x) < (64'sd1 <<< 59) && abs64(y) < (64'sd1 <<< 59)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < 22; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TAB[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TAB[i];
         end
      end
      u = (z + 512 * 65536 + (64'sd1 <<< (15 - FRAC))) >>> (16 - FRAC);
      return u - 512 * (64'sd1 <<< FRAC);
   endfunction

   // decide one defect under the current limits
   function automatic verdict_type judge_defect();
      longint sx, sy, ex, ey, fx, fy, cx, cy, d1, d2;
      longint ax, ay, bx, by, p1, p2, q1, q2, ang, unit;
      longint unsigned lhs, rh;
      verdict_type v;
      sx = req_start_x;  sy = req_start_y;
      ex = req_end_x;    ey = req_end_y;
      fx = req_far_x;    fy = req_far_y;
      cx = req_centre_x; cy = req_centre_y;
      unit = 64'sd1 <<< FRAC;
      v.tip = 1'b1;
      v.x = req_start_x;
      v.y = req_start_y;
      // direction from start toward centre
      if (sx == cx && sy == cy) begin
         v.tip = 1'b0;
      end else begin
         ang = angle_of(cx - sx, cy - sy);
         if (!(ang > longint'(lim_dir_lo) * unit && ang < longint'(lim_dir_hi) * unit))
            v.tip = 1'b0;
      end
      // apex is the endpoint farther from the far point, start on a tie
      d1 = (sx - fx) * (sx - fx) + (sy - fy) * (sy - fy);
      d2 = (ex - fx) * (ex - fx) + (ey - fy) * (ey - fy);
      if (d1 < d2) begin
         ax = ex; ay = ey; bx = sx; by = sy;
      end else begin
         ax = sx; ay = sy; bx = ex; by = ey;
      end
      p1 = bx - ax; p2 = by - ay;
      q1 = fx - ax; q2 = fy - ay;
      if ((p1 == 0 && p2 == 0) || (q1 == 0 && q2 == 0)) begin
         v.tip = 1'b0;
      end else begin
         ang = angle_of(p1 * q1 + p2 * q2, abs64(p1 * q2 - p2 * q1));
         if (!(ang > longint'(lim_apex_lo) * unit && ang < longint'(lim_apex_hi) * unit))
            v.tip = 1'b0;
      end
      // length against the box height fraction
      lhs = longint'(d1) * 1000000;
      rh = longint'(len_ratio) * longint'(req_box_height);
      if (!(lhs > rh * rh))
         v.tip = 1'b0;
      return v;
   endfunction

   assign pending = verdict_q.size();

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         lim_dir_lo  <= DIR_MIN_RST;
         lim_dir_hi  <= DIR_MAX_RST;
         lim_apex_lo <= APEX_MIN_RST;
         lim_apex_hi <= APEX_MAX_RST;
         len_ratio   <= LEN_RATIO_RST;
         verdict_q.delete();
         fail_count  <= 0;
      end else begin
         // compare each result with the oldest expectation
         if (rsp_valid) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result tip=%0b x=%0d y=%0d", $time,
                        rsp_is_fingertip, rsp_tip_x, rsp_tip_y);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_q.pop_front();
               if (want.tip !== rsp_is_fingertip || want.x !== rsp_tip_x ||
                   want.y !== rsp_tip_y) begin
                  $display("%0t: expected tip=%0b x=%0d y=%0d, got tip=%0b x=%0d y=%0d",
                           $time, want.tip, want.x, want.y,
                           rsp_is_fingertip, rsp_tip_x, rsp_tip_y);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict each accepted item
         if (start && !busy)
            verdict_q = {verdict_q, judge_defect()};
         // mirror register writes
         if (csr_we) begin
            case (csr_index)
               CSR_DIR_MIN:   lim_dir_lo  <= csr_wdata[8:0];
               CSR_DIR_MAX:   lim_dir_hi  <= csr_wdata[8:0];
               CSR_APEX_MIN:  lim_apex_lo <= csr_wdata[7:0];
               CSR_APEX_MAX:  lim_apex_hi <= csr_wdata[7:0];
               CSR_LEN_RATIO: len_ratio   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

@@ tb/fingertip_defect_filter_tb.sv @@
module fingertip_defect_filter_tb;
   import fdf_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 3'd7;
   localparam int PIPE_DRAIN = 40;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [CB-1:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic [CB-1:0] req_far_x = '0, req_far_y = '0, req_centre_x = '0, req_centre_y = '0;
   logic [CB-1:0] req_box_height = '0;
   logic          rsp_valid, rsp_is_fingertip;
   logic [CB-1:0] rsp_tip_x, rsp_tip_y;
   logic          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_DIR_MIN;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int            fail_count, pending;
   int            idle_pct;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   fingertip_defect_filter dut (.*);
   fingertip_defect_filter_checker chk (.*);

   // send one defect, idling first at the current rate
   task automatic send_defect(input logic [CB-1:0] sx, sy, ex, ey, fx, fy, cx, cy, h);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_start_x <= sx; req_start_y <= sy;
      req_end_x <= ex;   req_end_y <= ey;
      req_far_x <= fx;   req_far_y <= fy;
      req_centre_x <= cx; req_centre_y <= cy;
      req_box_height <= h;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
   endtask

   // one write, then csr_we drops again before the task returns
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // hold until the pipeline is empty, then load all five limits
   task automatic load_limits(input int dlo, dhi, alo, ahi, ratio);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      write_reg(CSR_DIR_MIN, dlo);
      write_reg(CSR_DIR_MAX, dhi);
      write_reg(CSR_APEX_MIN, alo);
      write_reg(CSR_APEX_MAX, ahi);
      write_reg(CSR_LEN_RATIO, ratio);
   endtask

   function automatic logic [CB-1:0] jitter(logic [CB-1:0] base, int span);
      int v;
      v = int'(base) + $urandom_range(2 * span) - span;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return CB'(v);
   endfunction

   // random defect: mostly a plausible hand shape, sometimes raw noise
   task automatic send_random();
      logic [CB-1:0] cx, cy, sx, sy, ex, ey, fx, fy, h;
      int span;
      if ($urandom_range(9) < 3) begin
         send_defect(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                     CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                     CB'($urandom));
      end else begin
         span = ($urandom_range(3) == 0) ? 2000 : $urandom_range(3, 300);
         cx = CB'($urandom); cy = CB'($urandom);
         sx = jitter(cx, span); sy = jitter(cy, span);
         ex = jitter(sx, span); ey = jitter(sy, span);
         fx = jitter(cx, span); fy = jitter(cy, span);
         h = CB'($urandom_range(4 * span));
         case ($urandom_range(15))
            0: begin sx = cx; sy = cy; end
            1: begin ex = sx; ey = sy; end
            2: begin fx = sx; fy = sy; end
            3: begin fx = ex; fy = ey; end
            4: h = 0;
            default: ;
         endcase
         send_defect(sx, sy, ex, ey, fx, fy, cx, cy, h);
      end
   endtask

   initial begin
      idle_pct = 18;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed defects under the reset limits
      send_defect(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_defect(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
      send_defect(100, 100, 100, 100, 50, 50, 200, 200, 100);
      send_defect(100, 100, 160, 100, 100, 100, 200, 200, 10);
      send_defect(100, 100, 200, 100, 150, 150, 100, 100, 10);
      send_defect(100, 100, 200, 100, 150, 160, 300, 300, 0);
      send_defect(100, 100, 200, 100, 150, 160, 300, 300, 4095);
      send_defect(100, 100, 200, 100, 150, 300, 300, 300, 100);
      send_defect(100, 100, 140, 100, 120, 150, 300, 300, 100);
      send_defect(200, 200, 100, 200, 150, 160, 100, 300, 100);
      send_defect(2000, 2000, 2100, 2000, 2050, 2300, 1000, 2000, 300);
      send_defect(2000, 2000, 2100, 2000, 2050, 2300, 1000, 1999, 300);
      send_defect(2000, 2000, 2100, 2000, 2050, 2300, 2000, 4095, 300);
      send_defect(2000, 2000, 2100, 2000, 2050, 2300, 2000, 0, 300);
      send_defect(0, 4095, 4095, 0, 0, 0, 4095, 4095, 4095);
      send_defect(4095, 0, 0, 4095, 4095, 4095, 0, 0, 1);
      send_defect(10, 10, 20, 10, 30, 10, 50, 60, 5);
      send_defect(10, 10, 20, 20, 30, 30, 50, 60, 5);
      send_defect(2730, 1365, 1365, 2730, 4095, 4095, 0, 4095, 2048);

      // random defects over six limit settings and three idle rates
      for (int seg = 0; seg < 6; seg++) begin
         idle_pct = (seg < 2) ? 18 : (seg < 4) ? 71 : 0;
         case (seg)
            0: load_limits(-180, 180, 0, 180, 0);
            1: load_limits(-30, 160, 20, 120, 1000);
            2: begin
               load_limits(180, -180, 180, 0, 1023);
               write_reg(CSR_UNMAPPED, $urandom);
            end
            3: load_limits($urandom_range(511), $urandom_range(511),
                           $urandom_range(255), $urandom_range(255), $urandom_range(1023));
            4: load_limits(-90, 90, 10, 170, 300);
            default: load_limits($urandom_range(360) - 180, $urandom_range(360) - 180,
                                 $urandom_range(180), $urandom_range(180),
                                 $urandom_range(1000));
         endcase
         repeat (306) send_random();
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #(8 * 200000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fdf_pkg.sv
rtl/core/fdf_cordic.sv
rtl/core/fingertip_defect_filter.sv
tb/fingertip_defect_filter_checker.sv
tb/fingertip_defect_filter_tb.sv
